[src/frame_deframer_sum_check_macros.svh]
// Assertion macros for the frame deframer checker.
// Every macro samples on i_clk and is held off while i_rst_n is low.
`ifndef FRAME_DEFRAMER_SUM_CHECK_MACROS_SVH
`define FRAME_DEFRAMER_SUM_CHECK_MACROS_SVH

// antecedent and consequent in the same cycle
`define FDSC_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("fdsc checker: same-cycle property failed");

// consequent in the cycle after the antecedent
`define FDSC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("fdsc checker: next-cycle property failed");

`endif

[src/fdsc_pkg.sv]
// ----------------------------------------------------------------------------
// fdsc_pkg
// Types and constants shared by the frame deframer and its step logic.
// ----------------------------------------------------------------------------
`default_nettype none

package fdsc_pkg;

    localparam logic [7:0]  HEAD_BYTE     = 8'hCC;
    localparam logic [31:0] MIN_LENGTH    = 32'd12;
    localparam logic [15:0] MAX_FRAME_RST = 16'd1024;

    // status codes of a result word
    localparam logic [2:0] ST_BUSY    = 3'd0;
    localparam logic [2:0] ST_OK      = 3'd1;
    localparam logic [2:0] ST_BADSUM  = 3'd2;
    localparam logic [2:0] ST_BADHEAD = 3'd3;
    localparam logic [2:0] ST_BADLEN  = 3'd4;

    typedef enum logic [2:0] {
        PH_HEAD = 3'b001,
        PH_LEN  = 3'b010,
        PH_BODY = 3'b100
    } t_phase;

    typedef struct packed {
        t_phase      phase;
        logic [15:0] pos;
        logic [31:0] len;
        logic [15:0] sum;
        logic [15:0] rx_sum;
        logic [15:0] cmd;
        logic [7:0]  adr;
        logic [7:0]  rslt;
    } t_state;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] command;
        logic [7:0]  address;
        logic [7:0]  result_code;
        logic [15:0] frame_length;
    } t_result;

    localparam t_state STATE_IDLE = '{
        phase:  PH_HEAD,
        pos:    16'd0,
        len:    32'd0,
        sum:    16'd0,
        rx_sum: 16'd0,
        cmd:    16'd0,
        adr:    8'd0,
        rslt:   8'd0
    };

endpackage

`default_nettype wire

[src/frame_deframer_sum_check.sv]
// ----------------------------------------------------------------------------
// frame_deframer_sum_check
// Length-prefixed frame deframer with 16-bit additive checksum.
// ----------------------------------------------------------------------------
// Every accepted byte produces exactly one result word in the next cycle, and a
// new byte is taken every cycle while the result register is empty or being
// drained. The rate is one byte per clock, set by the single state update per
// byte in fdsc_step; the result register decouples the two sides. Results with
// status in progress, bad head or bad length carry zero data; ok and checksum
// bad carry the captured command, address, result byte and length. The frame
// size limit is written through i_cfg_we/i_cfg_wdata and resets to 1024.
`default_nettype none

module frame_deframer_sum_check (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata,
    input  wire logic        s_axis_tvalid,
    output wire logic        s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,  // [7:0] rx_byte
    output wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [15:0] command, [23:16] address, [31:24] result_code, [47:32] frame_length
    output wire logic [47:0] m_axis_tdata,
    output wire logic [2:0]  m_axis_tuser   // [2:0] status
);

    logic [15:0]       r_max_frame;
    fdsc_pkg::t_state  r_state;
    fdsc_pkg::t_state  n_state;
    fdsc_pkg::t_result n_result;
    fdsc_pkg::t_result r_result;
    logic              r_out_valid;
    logic              in_fire;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    fdsc_step u_step (
        .i_state     (r_state),
        .i_byte      (s_axis_tdata),
        .i_max_frame (r_max_frame),
        .o_state     (n_state),
        .o_result    (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_frame <= fdsc_pkg::MAX_FRAME_RST;
        end else if (i_cfg_we) begin
            r_max_frame <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fdsc_pkg::STATE_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_result <= n_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_result.status;
    assign m_axis_tdata  = {r_result.frame_length, r_result.result_code,
                            r_result.address, r_result.command};

endmodule

`default_nettype wire

[src/fdsc_step.sv]
// ----------------------------------------------------------------------------
// fdsc_step
// Per-byte frame tracking: next deframer state and the result for one byte.
// ----------------------------------------------------------------------------
`default_nettype none

module fdsc_step (
    input  var fdsc_pkg::t_state  i_state,
    input  wire logic [7:0]       i_byte,
    input  wire logic [15:0]      i_max_frame,
    output var fdsc_pkg::t_state  o_state,
    output var fdsc_pkg::t_result o_result
);

    logic [31:0] len_new;
    logic [32:0] total;
    logic [31:0] pos_ext;

    assign pos_ext = {16'd0, i_state.pos};

    always_comb begin
        o_state  = i_state;
        o_result = '0;
        o_result.status = fdsc_pkg::ST_BUSY;
        len_new  = i_state.len;
        total    = '0;

        case (i_state.phase)
            fdsc_pkg::PH_LEN: begin
                // length bytes sit at positions 2..5, little endian
                case (i_state.pos[1:0])
                    2'd2:    len_new[7:0]   = i_state.len[7:0]   | i_byte;
                    2'd3:    len_new[15:8]  = i_state.len[15:8]  | i_byte;
                    2'd0:    len_new[23:16] = i_state.len[23:16] | i_byte;
                    default: len_new[31:24] = i_state.len[31:24] | i_byte;
                endcase
                total       = {1'b0, len_new} + 33'd4;
                o_state.len = len_new;
                o_state.sum = i_state.sum + {8'd0, i_byte};
                o_state.pos = i_state.pos + 16'd1;
                if (i_state.pos >= 16'd5) begin
                    if (total > {17'd0, i_max_frame} || len_new < fdsc_pkg::MIN_LENGTH) begin
                        o_state         = fdsc_pkg::STATE_IDLE;
                        o_result.status = fdsc_pkg::ST_BADLEN;
                    end else begin
                        o_state.phase = fdsc_pkg::PH_BODY;
                    end
                end
            end
            fdsc_pkg::PH_BODY: begin
                if (pos_ext < i_state.len) begin
                    o_state.sum = i_state.sum + {8'd0, i_byte};
                end
                case (i_state.pos)
                    16'd7:   o_state.cmd[7:0]  = i_byte;
                    16'd8:   o_state.cmd[15:8] = i_byte;
                    16'd10:  o_state.adr       = i_byte;
                    16'd11:  o_state.rslt      = i_byte;
                    default: ;
                endcase
                if (pos_ext == i_state.len) begin
                    o_state.rx_sum[7:0] = i_byte;
                end else if (pos_ext == i_state.len + 32'd1) begin
                    o_state.rx_sum[15:8] = i_byte;
                end
                // length was bounded to 16 bits at the length check
                if (pos_ext >= i_state.len + 32'd3) begin
                    o_result.status       = (o_state.sum == o_state.rx_sum) ?
                                            fdsc_pkg::ST_OK : fdsc_pkg::ST_BADSUM;
                    o_result.command      = o_state.cmd;
                    o_result.address      = o_state.adr;
                    o_result.result_code  = o_state.rslt;
                    o_result.frame_length = i_state.len[15:0];
                    o_state               = fdsc_pkg::STATE_IDLE;
                end else begin
                    o_state.pos = i_state.pos + 16'd1;
                end
            end
            default: begin
                // waiting for the two head bytes
                if (i_byte != fdsc_pkg::HEAD_BYTE) begin
                    o_state         = fdsc_pkg::STATE_IDLE;
                    o_result.status = fdsc_pkg::ST_BADHEAD;
                end else if (i_state.pos >= 16'd1) begin
                    o_state.phase = fdsc_pkg::PH_LEN;
                    o_state.pos   = 16'd2;
                end else begin
                    o_state.phase = fdsc_pkg::PH_HEAD;
                    o_state.pos   = 16'd1;
                end
            end
        endcase
    end

endmodule

`default_nettype wire

[src/fdsc_checker.sv]
// ----------------------------------------------------------------------------
// fdsc_checker
// Port-level checks for the frame deframer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "frame_deframer_sum_check_macros.svh"

module fdsc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [47:0] m_axis_tdata,
    input wire logic [2:0]  m_axis_tuser
);

    // a stalled result word holds
    `FDSC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // every accepted byte yields a result word next cycle
    `FDSC_ASSERT_NEXT(a_byte_gives_word, s_axis_tvalid && s_axis_tready, m_axis_tvalid)

    // an empty result register never blocks the input
    `FDSC_ASSERT_SAME(a_ready_when_empty, !m_axis_tvalid, s_axis_tready)

    // only completed frames carry data
    `FDSC_ASSERT_SAME(a_zero_data, m_axis_tvalid && (m_axis_tuser == fdsc_pkg::ST_BUSY || m_axis_tuser == fdsc_pkg::ST_BADHEAD || m_axis_tuser == fdsc_pkg::ST_BADLEN), m_axis_tdata == 48'd0)

    `FDSC_ASSERT_SAME(a_status_range, m_axis_tvalid, m_axis_tuser <= fdsc_pkg::ST_BADLEN)

endmodule

bind frame_deframer_sum_check fdsc_checker u_fdsc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
